/* hdl/sha256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int BlockBytes = 64;
    localparam int LenPos     = 56;
    localparam int Rounds     = 64;
    localparam logic [7:0] PadByte = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic        init_chain;   // restore initial values, clear count
        logic        write_byte;   // store byte at fill position
        logic        pad_byte;     // store 0x80 at fill position
        logic        zero_fill;    // sweep: write zero or length byte at fill position
        logic        load_work;    // working words from chain
        logic        do_round;     // one compression round
        logic        add_chain;    // fold working words into chain
        logic        clr_fill;
        logic        latch_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       block_full;    // fill reached 64
        logic       last_round;
        logic       pad_past_len;  // fill above 56 after the pad byte
        logic       fill_end;      // fill == 63
    } dp_stat_t;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

/* hdl/sha256_ctrl.sv */
// Controller state machine of the SHA-256 stream hasher
`timescale 1ns / 1ps
module sha256_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    input  logic                 out_busy,
    input  sha256_pkg::dp_stat_t stat,
    output logic                 in_stall,
    output logic                 out_load,
    output sha256_pkg::dp_cmd_t  cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic               final_reg, final_next;   // current compression is the last one
    logic               took;

    assign took = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256_pkg::ST_IDLE;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (took)
                begin
                    if (in_kind && stat.fill_end)
                    begin
                        // pad byte completes the block; length goes in a second one
                        state_next = sha256_pkg::ST_LOAD;
                        final_next = 1'b0;
                    end
                    else if (in_kind)
                        state_next = sha256_pkg::ST_PAD;
                    else if (stat.block_full)
                    begin
                        state_next = sha256_pkg::ST_LOAD;
                        final_next = 1'b0;
                    end
                end
            end
            sha256_pkg::ST_LOAD:  state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND: if (stat.last_round) state_next = sha256_pkg::ST_ADD;
            sha256_pkg::ST_ADD:
            begin
                if (final_reg)
                    state_next = sha256_pkg::ST_OUT;
                else if (stat.pad_past_len)
                    state_next = sha256_pkg::ST_PAD;   // spill block done, sweep again
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD:
            begin
                // zero/length sweep, one byte a cycle; compress at block end
                if (stat.fill_end)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                    final_next = !stat.pad_past_len;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (!out_busy)
                    state_next = sha256_pkg::ST_IDLE;
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.write_byte = took && !in_kind;
                cmd.pad_byte   = took && in_kind;
            end
            sha256_pkg::ST_LOAD:  cmd.load_work = 1'b1;
            sha256_pkg::ST_ROUND: cmd.do_round  = 1'b1;
            sha256_pkg::ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                cmd.clr_fill  = 1'b1;
                cmd.latch_out = final_reg;
            end
            sha256_pkg::ST_PAD:   cmd.zero_fill = 1'b1;
            sha256_pkg::ST_OUT:
            begin
                out_load       = !out_busy;
                cmd.init_chain = !out_busy;
            end
            default: ;
        endcase
    end

endmodule

/* hdl/sha256_dp.sv */
// Datapath of the SHA-256 stream hasher: block buffer, schedule, rounds, chain
`timescale 1ns / 1ps
module sha256_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output sha256_pkg::dp_stat_t stat,
    output logic [31:0]          digest [8],
    output logic                 overflow
);

    localparam logic [63:0] MaxBytes = 64'h1FFF_FFFF_FFFF_FFFF;

    logic [31:0] blk_reg [16];   // block held as big-endian words
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [63:0] cnt_reg;
    logic [6:0]  fill_reg;
    logic [5:0]  rnd_reg;
    logic        padded_reg;   // pad byte already went past the length slot
    logic [63:0] bits;
    logic [31:0] w_cur, t1, t2;
    logic [5:0]  fidx;
    logic [7:0]  sweep_byte;
    logic [5:0]  len_sh;

    assign fidx = fill_reg[5:0];
    assign bits = {cnt_reg[60:0], 3'b000};
    assign len_sh = fidx - 6'(sha256_pkg::LenPos);

    always_comb
    begin
        sweep_byte = 8'h00;
        if (cmd.zero_fill && !padded_reg && fidx >= 6'(sha256_pkg::LenPos))
            sweep_byte = bits[63 - 8*len_sh[2:0] -: 8];
    end

    always_comb
    begin
        if (rnd_reg < 6'd16)
            w_cur = blk_reg[rnd_reg[3:0]];
        else
            w_cur = w_reg[rnd_reg[3:0]] + sha256_pkg::sig0(w_reg[4'(rnd_reg[3:0] + 4'd1)])
                  + w_reg[4'(rnd_reg[3:0] + 4'd9)]
                  + sha256_pkg::sig1(w_reg[4'(rnd_reg[3:0] + 4'd14)]);
        t1 = v_reg[7] + sha256_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::RoundK[rnd_reg] + w_cur;
        t2 = sha256_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign stat.block_full   = (fill_reg == 7'd63) && cmd.write_byte;
    assign stat.last_round   = (rnd_reg == 6'd63);
    assign stat.pad_past_len = padded_reg;
    assign stat.fill_end     = (fill_reg == 7'd63);

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
            blk_reg[fidx[5:2]][{~fidx[1:0], 3'b000} +: 8] <= data_byte;
        else if (cmd.pad_byte)
            blk_reg[fidx[5:2]][{~fidx[1:0], 3'b000} +: 8] <= sha256_pkg::PadByte;
        else if (cmd.zero_fill)
            blk_reg[fidx[5:2]][{~fidx[1:0], 3'b000} +: 8] <= sweep_byte;
        if (cmd.do_round)
            w_reg[rnd_reg[3:0]] <= w_cur;
        if (cmd.load_work)
            for (int j = 0; j < 8; j++)
                v_reg[j] <= h_reg[j];
        else if (cmd.do_round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    // chain, byte count, fill position, pad flag and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
                h_reg[j] <= sha256_pkg::InitH[j];
            cnt_reg    <= '0;
            fill_reg   <= '0;
            rnd_reg    <= '0;
            padded_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_chain)
            begin
                for (int j = 0; j < 8; j++)
                    h_reg[j] <= sha256_pkg::InitH[j];
                cnt_reg    <= '0;
                padded_reg <= 1'b0;
            end
            else if (cmd.add_chain)
                for (int j = 0; j < 8; j++)
                    h_reg[j] <= h_reg[j] + v_reg[j];
            if (cmd.write_byte)
            begin
                fill_reg <= fill_reg + 7'd1;
                if (cnt_reg != '1)
                    cnt_reg <= cnt_reg + 64'd1;
            end
            else if (cmd.pad_byte)
            begin
                fill_reg   <= fill_reg + 7'd1;
                padded_reg <= (fill_reg >= 7'(sha256_pkg::LenPos));
            end
            else if (cmd.zero_fill)
                fill_reg <= fill_reg + 7'd1;
            if (cmd.clr_fill)
                fill_reg <= '0;
            if (cmd.add_chain && !cmd.latch_out)
                padded_reg <= 1'b0;
            if (cmd.do_round)
                rnd_reg <= rnd_reg + 6'd1;
            else
                rnd_reg <= '0;
        end
    end

    always_comb
    begin
        overflow = cnt_reg > MaxBytes;
        for (int j = 0; j < 8; j++)
            digest[j] = overflow ? 32'd0 : h_reg[j];
    end

endmodule

/* hdl/sha256_stream_hasher_top.sv */
// Top level of the SHA-256 stream hasher
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, kind, data_byte       | request in
//  out     | out_valid, out_stall, digest_word_0..7,   | request out
//          | length_overflow                           |
//
// A data byte is stored while idle; the 64th byte of a block starts a compression
// (load, 64 rounds, chain add) on the single shared round unit.
// Finish sweeps the rest of the block a byte a cycle, compresses once or
// twice, then holds the digest in the output register until taken.
// rst_n clears control, count and chain at once; no clearing pass.
// Input is stalled while compressing or sweeping, and while a new digest
// waits for the previous one to leave the output register.
`timescale 1ns / 1ps
module sha256_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word_0,
    output logic [31:0] digest_word_1,
    output logic [31:0] digest_word_2,
    output logic [31:0] digest_word_3,
    output logic [31:0] digest_word_4,
    output logic [31:0] digest_word_5,
    output logic [31:0] digest_word_6,
    output logic [31:0] digest_word_7,
    output logic        length_overflow
);

    sha256_pkg::dp_cmd_t  cmd;
    sha256_pkg::dp_stat_t stat;
    logic [31:0]          digest [8];
    logic [31:0]          dig_reg [8];
    logic                 ovf_reg;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 length_overflow_w;

    sha256_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (kind),
        .out_busy (out_valid_reg && out_stall),
        .stat     (stat),
        .in_stall (in_stall),
        .out_load (out_load),
        .cmd      (cmd)
    );

    sha256_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .stat      (stat),
        .digest    (digest),
        .overflow  (length_overflow_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dig_reg <= digest;
            ovf_reg <= length_overflow_w;
        end
    end

    assign out_valid       = out_valid_reg;
    assign digest_word_0   = dig_reg[0];
    assign digest_word_1   = dig_reg[1];
    assign digest_word_2   = dig_reg[2];
    assign digest_word_3   = dig_reg[3];
    assign digest_word_4   = dig_reg[4];
    assign digest_word_5   = dig_reg[5];
    assign digest_word_6   = dig_reg[6];
    assign digest_word_7   = dig_reg[7];
    assign length_overflow = ovf_reg;

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_round || cmd.load_work) |-> in_stall)
        else $error("input taken during compression");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("digest load lost");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !out_load)
        else $error("pending digest overwritten");

endmodule

/* sim/sha256_stream_hasher_top_test.sv */
// Testbench for the SHA-256 stream hasher: directed and random byte messages checked against a local hash model
`timescale 1ns / 1ps
module sha256_stream_hasher_top_test;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam longint unsigned LIMIT_CYCLES = 2000000;
    localparam longint unsigned MAX_MSG_BYTES = 64'h1FFFFFFFFFFFFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } hash_req_t;

    typedef struct packed {
        logic [7:0][31:0] words;
        logic             overflow;
    } digest_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word_0, digest_word_1, digest_word_2, digest_word_3;
    logic [31:0] digest_word_4, digest_word_5, digest_word_6, digest_word_7;
    logic        length_overflow;

    sha256_stream_hasher_top DUT (.*);

    hash_req_t pending_reqs[$];
    digest_t   expected_digests[$];

    // hashing state of the model
    logic [31:0]     chain_h[8];
    logic [7:0]      msg_block[64];
    longint unsigned msg_len;
    int              block_fill;

    int  mismatch_count;
    bit  stim_done;
    longint unsigned cycle_count;
    int  burst_left;
    int  gap_left;
    int  stall_phase;
    int  stall_mode;

    // sampled handshake state from the last rising edge
    logic in_stall_at_edge;
    initial in_stall_at_edge = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_block();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + sha256_pkg::RoundK[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
        begin
            chain_h[i] = sha256_pkg::InitH[i];
        end
        msg_len = 0;
        block_fill = 0;
    endtask

    task automatic predict_digest(hash_req_t r);
        digest_t         res;
        logic            over;
        longint unsigned bits;
        if (r.kind == KIND_DATA)
        begin
            msg_block[block_fill] = r.data_byte;
            block_fill++;
            if (msg_len != 64'hFFFFFFFFFFFFFFFF)
                msg_len++;
            if (block_fill == 64)
            begin
                hash_block();
                block_fill = 0;
            end
            return;
        end
        over = msg_len > MAX_MSG_BYTES;
        bits = (msg_len & MAX_MSG_BYTES) << 3;
        msg_block[block_fill] = sha256_pkg::PadByte;
        block_fill++;
        if (block_fill > sha256_pkg::LenPos)
        begin
            for (int i = block_fill; i < 64; i++)
                msg_block[i] = 8'h00;
            hash_block();
            block_fill = 0;
        end
        for (int i = block_fill; i < sha256_pkg::LenPos; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[sha256_pkg::LenPos + i] = bits[(7 - i) * 8 +: 8];
        hash_block();
        for (int i = 0; i < 8; i++)
            res.words[i] = over ? 32'h0 : chain_h[i];
        res.overflow = over;
        expected_digests.push_back(res);
        restart_message();
    endtask

    task automatic queue_message(int len, int style);
        hash_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.kind = KIND_DATA;
            case (style)
                0: r.data_byte = 8'h00;
                1: r.data_byte = 8'hFF;
                default: r.data_byte = 8'($urandom);
            endcase
            pending_reqs.push_back(r);
        end
        r.kind = KIND_FINISH;
        r.data_byte = 8'($urandom);
        pending_reqs.push_back(r);
    endtask

    // stimulus
    initial
    begin
        int total;
        int len;
        restart_message();
        mismatch_count = 0;
        stim_done = 0;
        // empty message, padding boundaries, all-zero and all-one bytes
        queue_message(0, 2);
        queue_message(1, 0);
        queue_message(3, 1);
        queue_message(55, 2);
        queue_message(56, 2);
        queue_message(63, 0);
        queue_message(64, 1);
        queue_message(65, 2);
        queue_message(119, 2);
        queue_message(128, 2);
        total = pending_reqs.size();
        while (total < 1350)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 40);
            endcase
            queue_message(len, 2);
            total += len + 1;
        end
        stim_done = 1;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: bursts with random gaps
    initial
    begin
        in_valid = 1'b0;
        kind = KIND_DATA;
        data_byte = 8'h00;
        burst_left = 0;
        gap_left = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall_at_edge)
                void'(pending_reqs.pop_front());
            if (in_valid && in_stall_at_edge)
            begin
                // hold the request
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                in_valid <= 1'b1;
                kind <= pending_reqs[0].kind;
                data_byte <= pending_reqs[0].data_byte;
                burst_left--;
                if (burst_left == 0 && $urandom_range(0, 2) != 0)
                    gap_left = $urandom_range(1, 6);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        stall_phase = 0;
        stall_mode = 0;
    end

    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase % 97 == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= (stall_phase % 7 < 4);
        endcase
    end

    // monitor: model on accepted requests, check on accepted digests
    always @(posedge clk)
    begin
        digest_t got;
        digest_t exp_d;
        hash_req_t r;
        in_stall_at_edge <= in_stall;
        if (rst_n)
        begin
            cycle_count++;
            if (in_valid && !in_stall)
            begin
                r.kind = kind;
                r.data_byte = data_byte;
                predict_digest(r);
            end
            if (out_valid && !out_stall)
            begin
                got.words = {digest_word_7, digest_word_6, digest_word_5, digest_word_4,
                             digest_word_3, digest_word_2, digest_word_1, digest_word_0};
                got.overflow = length_overflow;
                if (expected_digests.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected digest %h ovf %b", got.words, got.overflow);
                end
                else
                begin
                    exp_d = expected_digests.pop_front();
                    for (int i = 0; i < 8; i++)
                    begin
                        if (got.words[i] !== exp_d.words[i])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("digest_word_%0d exp %h got %h", i,
                                         exp_d.words[i], got.words[i]);
                        end
                    end
                    if (got.overflow !== exp_d.overflow)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("length_overflow exp %b got %b",
                                     exp_d.overflow, got.overflow);
                    end
                end
            end
        end
    end

    initial cycle_count = 0;

    // end of run
    initial
    begin
        wait (stim_done);
        while ((pending_reqs.size() > 0 || in_valid || expected_digests.size() > 0)
               && cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (mismatch_count == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
